// ===== hw/rtl/glz_pkg.sv =====
// Shared types and constants for the GIF LZW code generator.
`timescale 1ns / 1ps
package glz_pkg;

  localparam int unsigned MaxCodes  = 4096;
  localparam int unsigned HashSlots = 8192;
  localparam int unsigned SlotAw    = $clog2(HashSlots);
  localparam int unsigned CodeW     = 12;
  localparam int unsigned NextW     = $clog2(MaxCodes) + 1;
  localparam int unsigned SymW      = 8;
  localparam int unsigned KeyW      = CodeW + SymW;
  localparam int unsigned EpochW    = 4;
  localparam int unsigned SizeW     = 4;
  localparam logic [SizeW-1:0] SizeMin   = 4'd2;
  localparam logic [SizeW-1:0] SizeMax   = 4'd8;
  localparam logic [SizeW-1:0] SizeReset = 4'd8;
  localparam logic [SizeW-1:0] WidthMax  = 4'd12;

  typedef logic [SlotAw-1:0] slot_addr_t;

  // One dictionary slot: epoch mark, key and assigned code.
  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [KeyW-1:0]   key;
    logic [CodeW-1:0]  code;
  } slot_t;

  typedef struct packed {
    logic       en;
    slot_addr_t addr;
    slot_t      data;
  } slot_wr_t;

  typedef struct packed {
    logic       en;
    slot_addr_t addr;
  } slot_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_EMIT_START,
    ST_EMIT_PREFIX,
    ST_EMIT_CLEAR,
    ST_EMIT_FINAL,
    ST_EMIT_EOI,
    ST_SWEEP
  } glz_state_e;

  // Open-addressed hash of prefix and symbol.
  function automatic slot_addr_t slot_hash(logic [KeyW-1:0] key);
    logic [CodeW+3:0] h;
    h = {key[KeyW-1:SymW], 4'b0000} ^ {8'b0000_0000, key[SymW-1:0]};
    return h[SlotAw-1:0];
  endfunction

endpackage

// ===== hw/rtl/glz_sym_if.sv =====
// Valid/ready channel carrying one pixel index request.
`timescale 1ns / 1ps
interface glz_sym_if;
  import glz_pkg::*;
  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            last_symbol;
  modport source (output valid, symbol, last_symbol, input ready);
  modport sink   (input valid, symbol, last_symbol, output ready);
endinterface

// ===== hw/rtl/glz_code_if.sv =====
// Valid/ready channel carrying one emitted LZW code request.
`timescale 1ns / 1ps
interface glz_code_if;
  import glz_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code;
  logic [SizeW-1:0] code_width;
  logic             end_of_run;
  logic             end_of_image;
  modport source (output valid, code, code_width, end_of_run, end_of_image, input ready);
  modport sink   (input valid, code, code_width, end_of_run, end_of_image, output ready);
endinterface

// ===== hw/rtl/glz_dict.sv =====
// Dictionary slot memory: one write and one registered read per cycle.
`timescale 1ns / 1ps
module glz_dict
  import glz_pkg::*;
(
  input  logic     clk_i,
  input  slot_rd_t rd_i,
  input  slot_wr_t wr_i,
  output slot_t    rd_data_o
);

  slot_t mem [HashSlots];
  slot_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/gif_lzw_code_generator_top.sv =====
// Top level of the GIF LZW code generator.
`timescale 1ns / 1ps
// Usage:
//   sym_in carries pixel indices; last_symbol marks the final index of an image.
//   code_out carries LZW codes with their bit width; end_of_run flags the last
//   code caused by one index, end_of_image flags the EOI code.
//   cfg_we_i/cfg_wdata_i write min_code_size; it is taken at the next image start.
// Sequencing:
//   One index at a time. A dictionary hit is an accept, then a compare on the
//   registered slot read; each colliding slot adds a probe of the next slot.
//   A miss then emits one code per emit state, up to four codes per index.
// Reset and clearing:
//   Slots carry a 4-bit epoch mark; a table restart bumps the epoch. After reset
//   and whenever the epoch wraps, a pass writes all 8192 slots, one per cycle,
//   during which no index is accepted.
// Stalls:
//   Codes leave through an output register; when the receiver stalls, the block
//   holds in its emit state until the register frees up.
module gif_lzw_code_generator_top
  import glz_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  glz_sym_if.sink          sym_in,
  glz_code_if.source       code_out
);

  glz_state_e state_q, state_d;
  logic [SizeW-1:0]  cfg_q;
  logic [SizeW-1:0]  act_q, act_d;
  logic              have_q, have_d;
  logic [CodeW-1:0]  prefix_q, prefix_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic              last_q, last_d;
  logic [NextW-1:0]  next_q, next_d;
  logic [SizeW-1:0]  width_q, width_d;
  slot_addr_t        idx_q, idx_d;
  logic [EpochW-1:0] epoch_q, epoch_d;
  logic              sweep_q, sweep_d;
  slot_addr_t        sweep_cnt_q, sweep_cnt_d;

  logic             out_valid_q;
  logic [CodeW-1:0] out_code_q;
  logic [SizeW-1:0] out_width_q;
  logic             out_eor_q;
  logic             out_eoi_q;

  slot_rd_t rd;
  slot_wr_t wr;
  slot_t    rd_data;

  logic             accept;
  logic             emit_req;
  logic             emit_fire;
  logic [CodeW-1:0] emit_code;
  logic             emit_eor;
  logic             emit_eoi;
  logic [SizeW-1:0] size_clamped;
  logic [SizeW-1:0] size_sel;
  logic [SymW-1:0]  sym_masked;
  logic [CodeW-1:0] clr_code;
  logic             slot_live;
  logic             table_full;
  logic [CodeW:0]   grow_at;

  glz_dict u_dict (
    .clk_i     (clk_i),
    .rd_i      (rd),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  // Input side helpers
  assign size_clamped = (cfg_q < SizeMin) ? SizeMin : ((cfg_q > SizeMax) ? SizeMax : cfg_q);
  assign size_sel     = have_q ? act_q : size_clamped;
  assign sym_masked   = sym_in.symbol & SymW'((9'h1 << size_sel) - 9'h1);
  assign clr_code     = CodeW'(13'h1 << act_q);
  assign slot_live    = (rd_data.epoch == epoch_q);
  assign table_full   = (next_q >= NextW'(MaxCodes));
  assign grow_at      = (CodeW + 1)'((14'h1 << width_q) - 14'h1);

  assign sym_in.ready = (state_q == ST_IDLE) && !sweep_q;
  assign accept       = sym_in.valid && sym_in.ready;
  assign emit_fire    = emit_req && (!out_valid_q || code_out.ready);

  // Output selection per state
  always_comb begin
    emit_req  = 1'b0;
    emit_code = prefix_q;
    emit_eor  = 1'b0;
    emit_eoi  = 1'b0;
    case (state_q)
      ST_EMIT_START: begin
        emit_req  = 1'b1;
        emit_code = clr_code;
        emit_eor  = !last_q;
      end
      ST_EMIT_PREFIX: begin
        emit_req = 1'b1;
        emit_eor = !table_full && !last_q;
      end
      ST_EMIT_CLEAR: begin
        emit_req  = 1'b1;
        emit_code = clr_code;
        emit_eor  = !last_q;
      end
      ST_EMIT_FINAL: begin
        emit_req = 1'b1;
      end
      ST_EMIT_EOI: begin
        emit_req  = 1'b1;
        emit_code = clr_code + CodeW'(1);
        emit_eor  = 1'b1;
        emit_eoi  = 1'b1;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  // Next state and datapath updates
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    have_d      = have_q;
    prefix_d    = prefix_q;
    sym_d       = sym_q;
    last_d      = last_q;
    next_d      = next_q;
    width_d     = width_q;
    idx_d       = idx_q;
    epoch_d     = epoch_q;
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    rd          = '0;
    wr          = '0;
    case (state_q)
      ST_IDLE: begin
        if (sweep_q) begin
          state_d     = ST_SWEEP;
          sweep_cnt_d = '0;
        end else if (accept) begin
          sym_d  = sym_masked;
          last_d = sym_in.last_symbol;
          if (!have_q) begin
            // Start an image: restart the table at the new code size
            act_d    = size_clamped;
            have_d   = 1'b1;
            prefix_d = CodeW'(sym_masked);
            next_d   = NextW'((14'h1 << size_clamped) + 14'd2);
            width_d  = size_clamped + SizeW'(1);
            if (&epoch_q) sweep_d = 1'b1;
            else          epoch_d = epoch_q + EpochW'(1);
            state_d  = ST_EMIT_START;
          end else begin
            idx_d   = slot_hash({prefix_q, sym_masked});
            rd.en   = 1'b1;
            rd.addr = idx_d;
            state_d = ST_COMPARE;
          end
        end
      end
      ST_COMPARE: begin
        if (slot_live && rd_data.key == {prefix_q, sym_q}) begin
          prefix_d = rd_data.code;
          state_d  = last_q ? ST_EMIT_FINAL : ST_IDLE;
        end else if (slot_live) begin
          // Collision: probe the next slot
          idx_d   = idx_q + slot_addr_t'(1);
          rd.en   = 1'b1;
          rd.addr = idx_d;
        end else begin
          // Miss: claim the free slot unless the code space is used up
          if (!table_full) begin
            wr.en         = 1'b1;
            wr.addr       = idx_q;
            wr.data.epoch = epoch_q;
            wr.data.key   = {prefix_q, sym_q};
            wr.data.code  = next_q[CodeW-1:0];
          end
          state_d = ST_EMIT_PREFIX;
        end
      end
      ST_EMIT_START: begin
        if (emit_fire) state_d = last_q ? ST_EMIT_FINAL : ST_IDLE;
      end
      ST_EMIT_PREFIX: begin
        if (emit_fire) begin
          if (table_full) begin
            state_d = ST_EMIT_CLEAR;
          end else begin
            if (next_q == grow_at && width_q < WidthMax) begin
              width_d = width_q + SizeW'(1);
            end
            next_d   = next_q + NextW'(1);
            prefix_d = CodeW'(sym_q);
            state_d  = last_q ? ST_EMIT_FINAL : ST_IDLE;
          end
        end
      end
      ST_EMIT_CLEAR: begin
        if (emit_fire) begin
          next_d   = NextW'((14'h1 << act_q) + 14'd2);
          width_d  = act_q + SizeW'(1);
          if (&epoch_q) sweep_d = 1'b1;
          else          epoch_d = epoch_q + EpochW'(1);
          prefix_d = CodeW'(sym_q);
          state_d  = last_q ? ST_EMIT_FINAL : ST_IDLE;
        end
      end
      ST_EMIT_FINAL: begin
        if (emit_fire) state_d = ST_EMIT_EOI;
      end
      ST_EMIT_EOI: begin
        if (emit_fire) begin
          have_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // Stamp every slot with the retired epoch zero
        wr.en       = 1'b1;
        wr.addr     = sweep_cnt_q;
        sweep_cnt_d = sweep_cnt_q + slot_addr_t'(1);
        if (&sweep_cnt_q) begin
          epoch_d = EpochW'(1);
          sweep_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= SizeReset;
      act_q       <= SizeReset;
      have_q      <= 1'b0;
      prefix_q    <= '0;
      next_q      <= NextW'((14'h1 << SizeReset) + 14'd2);
      width_q     <= SizeReset + SizeW'(1);
      epoch_q     <= '0;
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      act_q       <= act_d;
      have_q      <= have_d;
      prefix_q    <= prefix_d;
      next_q      <= next_d;
      width_q     <= width_d;
      epoch_q     <= epoch_d;
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
      last_q      <= last_d;
      if (emit_fire)           out_valid_q <= 1'b1;
      else if (code_out.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    idx_q <= idx_d;
    if (emit_fire) begin
      out_code_q  <= emit_code;
      out_width_q <= width_q;
      out_eor_q   <= emit_eor;
      out_eoi_q   <= emit_eoi;
    end
  end

  assign code_out.valid        = out_valid_q;
  assign code_out.code         = out_code_q;
  assign code_out.code_width   = out_width_q;
  assign code_out.end_of_run   = out_eor_q;
  assign code_out.end_of_image = out_eoi_q;

endmodule

// ===== hw/rtl/glz_checker.sv =====
// Port-level assertions for the GIF LZW code generator, bound to the top level.
`timescale 1ns / 1ps
module glz_checker
  import glz_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CodeW-1:0] out_code_i,
  input logic [SizeW-1:0] out_width_i,
  input logic             out_eor_i,
  input logic             out_eoi_i
);

  // Hold a stalled request
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("code request dropped while stalled");

  // Keep a stalled code and width steady
  a_code_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_code_i) && $stable(out_width_i))
    else $error("code payload changed while stalled");

  // End of image always closes the run
  a_eoi_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_eoi_i |-> out_eor_i)
    else $error("EOI code without end of run");

  // Code width stays within the LZW range
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_width_i >= 4'd3 && out_width_i <= 4'd12)
    else $error("code width out of range");

endmodule

bind gif_lzw_code_generator_top glz_checker u_glz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (code_out.valid),
  .out_ready_i (code_out.ready),
  .out_code_i  (code_out.code),
  .out_width_i (code_out.code_width),
  .out_eor_i   (code_out.end_of_run),
  .out_eoi_i   (code_out.end_of_image)
);
